[src/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[src/sem_pkg.sv]
package sem_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    localparam int PIX_W   = 24;
    localparam int COL_W   = 10;
    localparam int ROW_W   = 13;
    localparam int OROW_W  = 12;
    localparam int CFG_WW  = 11;
    localparam int CFG_HW  = 13;
    localparam int SUM_W   = 21;

    localparam logic [SUM_W-1:0] SAT_LIMIT = SUM_W'(65280);

    localparam logic REG_IDX_WIDTH  = 1'b0;
    localparam logic REG_IDX_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0] t_pix;

    typedef struct packed {
        logic       action;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       frame_end;
    } t_pix_out;

endpackage

[src/sem_ram.sv]
module sem_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[src/sobel_edge_magnitude_rgb_unit.sv]
// an item that gives a result passes through ST_CALC, ST_SQR, ST_SUM, ST_ROOT and ST_FIN before it is offered
// a new item is taken only in ST_IDLE, so each item, with its 8-step square root, is finished before the next
// an item that gives no result passes only through ST_CALC; a drain item during the frame is dropped in ST_IDLE
// a result waiting on a stalled output holds off the next item
// reset: synchronous active-low; width 640, height 480, counters and window cleared
// line stores are not cleared and hold nothing valid until written

`include "assert_macros.svh"

module sobel_edge_magnitude_rgb_unit import sem_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_pix_in     i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_pix_out    o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_CALC, ST_SQR, ST_SUM, ST_ROOT, ST_FIN
    } t_state;

    t_state                   r_state;
    logic [CFG_WW-1:0]        r_cfg_w;
    logic [CFG_HW-1:0]        r_cfg_h;
    logic [COL_W-1:0]         r_in_column;
    logic [ROW_W-1:0]         r_in_row;
    logic [COL_W-1:0]         r_out_column;
    logic [OROW_W-1:0]        r_out_row;
    t_pix                     r_win [3][2];
    t_pix                     r_px;
    logic                     r_fe;
    logic signed [10:0]       r_gx [3];
    logic signed [10:0]       r_gy [3];
    logic [19:0]              r_gx2 [3];
    logic [19:0]              r_gy2 [3];
    logic [SUM_W-1:0]         r_s [3];
    logic [7:0]               r_n [3];
    logic [2:0]               r_bit;
    logic                     r_out_valid;
    t_pix_out                 r_out;

    logic [CFG_WW-1:0]        w_eff;
    logic [CFG_HW-1:0]        h_eff;
    logic                     cfg_wr;
    logic                     in_acc;
    logic                     filling;
    logic                     out_busy;
    t_pix                     rd_upper;
    t_pix                     rd_lower;
    t_pix                     top;
    t_pix                     mid;
    t_pix                     loc [3][3];
    t_pix                     newcol [3];
    logic                     emit;
    logic                     col_last;
    logic                     frame_last;
    logic signed [10:0]       n_gx [3];
    logic signed [10:0]       n_gy [3];
    logic [7:0]               n_n [3];
    logic [7:0]               n_mag [3];

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = paddr[2] ? {19'b0, r_cfg_h} : {21'b0, r_cfg_w};

    always_comb begin
        if (r_cfg_w == '0) begin
            w_eff = CFG_WW'(1);
        end else if (r_cfg_w > CFG_WW'(MAX_WIDTH)) begin
            w_eff = CFG_WW'(MAX_WIDTH);
        end else begin
            w_eff = r_cfg_w;
        end
        if (r_cfg_h == '0) begin
            h_eff = CFG_HW'(1);
        end else if (r_cfg_h > CFG_HW'(MAX_HEIGHT)) begin
            h_eff = CFG_HW'(MAX_HEIGHT);
        end else begin
            h_eff = r_cfg_h;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_acc      = i_in_valid && (r_state == ST_IDLE);
    assign filling     = r_in_row < h_eff;
    assign out_busy    = r_out_valid && i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
        .i_clk     (i_clk),
        .i_wr_en   (r_state == ST_CALC),
        .i_wr_addr (r_in_column),
        .i_wr_data (mid),
        .i_rd_en   (in_acc),
        .i_rd_addr (r_in_column),
        .o_rd_data (rd_upper)
    );

    sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_lower (
        .i_clk     (i_clk),
        .i_wr_en   (r_state == ST_CALC),
        .i_wr_addr (r_in_column),
        .i_wr_data (r_px),
        .i_rd_en   (in_acc),
        .i_rd_addr (r_in_column),
        .o_rd_data (rd_lower)
    );

    // window assembly and gradients
    always_comb begin
        logic [9:0] pl, pr, pt, pb;
        top = (r_in_row >= ROW_W'(2)) ? rd_upper : '0;
        mid = (r_in_row >= ROW_W'(1)) ? rd_lower : '0;
        newcol[0] = top;
        newcol[1] = mid;
        newcol[2] = r_px;
        emit = (r_in_column == '0) ? (r_in_row >= ROW_W'(2)) : (r_in_row >= ROW_W'(1));
        col_last   = (11'(r_out_column) + 11'd1) >= w_eff;
        frame_last = col_last && ((13'(r_out_row) + 13'd1) >= h_eff);
        for (int r = 0; r < 3; r++) begin
            loc[r][0] = (r_out_column == '0) ? '0 : r_win[r][0];
            loc[r][1] = r_win[r][1];
            loc[r][2] = (col_last || r_in_column == '0) ? '0 : newcol[r];
        end
        for (int k = 0; k < 3; k++) begin
            pr = 10'(loc[0][2][8*(2-k) +: 8]) + {1'b0, loc[1][2][8*(2-k) +: 8], 1'b0}
               + 10'(loc[2][2][8*(2-k) +: 8]);
            pl = 10'(loc[0][0][8*(2-k) +: 8]) + {1'b0, loc[1][0][8*(2-k) +: 8], 1'b0}
               + 10'(loc[2][0][8*(2-k) +: 8]);
            pb = 10'(loc[2][0][8*(2-k) +: 8]) + {1'b0, loc[2][1][8*(2-k) +: 8], 1'b0}
               + 10'(loc[2][2][8*(2-k) +: 8]);
            pt = 10'(loc[0][0][8*(2-k) +: 8]) + {1'b0, loc[0][1][8*(2-k) +: 8], 1'b0}
               + 10'(loc[0][2][8*(2-k) +: 8]);
            n_gx[k] = $signed({1'b0, pr}) - $signed({1'b0, pl});
            n_gy[k] = $signed({1'b0, pb}) - $signed({1'b0, pt});
        end
    end

    // one root bit per cycle, then rounding and saturation
    always_comb begin
        logic [7:0]  t;
        logic [15:0] sq;
        logic [16:0] nn;
        for (int k = 0; k < 3; k++) begin
            t  = r_n[k] | (8'd1 << r_bit);
            sq = 16'(t) * 16'(t);
            n_n[k] = (SUM_W'(sq) <= r_s[k]) ? t : r_n[k];
            nn = 17'(16'(r_n[k]) * 16'(r_n[k])) + 17'(r_n[k]);
            if (r_s[k] > SAT_LIMIT) begin
                n_mag[k] = 8'd255;
            end else if (r_s[k] > SUM_W'(nn)) begin
                n_mag[k] = r_n[k] + 8'd1;
            end else begin
                n_mag[k] = r_n[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cfg_w      <= CFG_WW'(640);
            r_cfg_h      <= CFG_HW'(480);
            r_in_column  <= '0;
            r_in_row     <= '0;
            r_out_column <= '0;
            r_out_row    <= '0;
            r_out_valid  <= 1'b0;
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= '0;
                r_win[r][1] <= '0;
            end
        end else begin
            if ((r_state == ST_FIN) && !out_busy) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc && !(i_in_data.action && filling)) begin
                        r_px <= (filling && !i_in_data.action)
                              ? {i_in_data.red_in, i_in_data.green_in, i_in_data.blue_in}
                              : '0;
                        r_state <= ST_CALC;
                    end
                end
                ST_CALC: begin
                    for (int k = 0; k < 3; k++) begin
                        r_gx[k] <= n_gx[k];
                        r_gy[k] <= n_gy[k];
                    end
                    r_fe <= frame_last;
                    if (emit && frame_last) begin
                        r_in_column  <= '0;
                        r_in_row     <= '0;
                        r_out_column <= '0;
                        r_out_row    <= '0;
                        for (int r = 0; r < 3; r++) begin
                            r_win[r][0] <= '0;
                            r_win[r][1] <= '0;
                        end
                    end else begin
                        for (int r = 0; r < 3; r++) begin
                            r_win[r][0] <= r_win[r][1];
                            r_win[r][1] <= newcol[r];
                        end
                        if ((11'(r_in_column) + 11'd1) >= w_eff) begin
                            r_in_column <= '0;
                            r_in_row    <= r_in_row + ROW_W'(1);
                        end else begin
                            r_in_column <= r_in_column + COL_W'(1);
                        end
                        if (emit) begin
                            if (col_last) begin
                                r_out_column <= '0;
                                r_out_row    <= r_out_row + OROW_W'(1);
                            end else begin
                                r_out_column <= r_out_column + COL_W'(1);
                            end
                        end
                    end
                    if (emit) begin
                        r_state <= ST_SQR;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_SQR: begin
                    for (int k = 0; k < 3; k++) begin
                        r_gx2[k] <= 20'(22'(r_gx[k] * r_gx[k]));
                        r_gy2[k] <= 20'(22'(r_gy[k] * r_gy[k]));
                    end
                    r_state <= ST_SUM;
                end
                ST_SUM: begin
                    for (int k = 0; k < 3; k++) begin
                        r_s[k] <= SUM_W'(r_gx2[k]) + SUM_W'(r_gy2[k]);
                        r_n[k] <= '0;
                    end
                    r_bit   <= 3'd7;
                    r_state <= ST_ROOT;
                end
                ST_ROOT: begin
                    for (int k = 0; k < 3; k++) begin
                        r_n[k] <= n_n[k];
                    end
                    r_bit <= r_bit - 3'd1;
                    if (r_bit == 3'd0) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (!out_busy) begin
                        r_out.red_out   <= n_mag[0];
                        r_out.green_out <= n_mag[1];
                        r_out.blue_out  <= n_mag[2];
                        r_out.frame_end <= r_fe;
                        r_state         <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            // register write restarts the frame
            if (cfg_wr) begin
                unique case (paddr[2])
                    REG_IDX_WIDTH:  r_cfg_w <= pwdata[CFG_WW-1:0];
                    REG_IDX_HEIGHT: r_cfg_h <= pwdata[CFG_HW-1:0];
                endcase
                r_in_column  <= '0;
                r_in_row     <= '0;
                r_out_column <= '0;
                r_out_row    <= '0;
                for (int r = 0; r < 3; r++) begin
                    r_win[r][0] <= '0;
                    r_win[r][1] <= '0;
                end
            end
        end
    end

    `ASSERT_NEXT(a_fin_holds, i_clk, i_rst_n, (r_state == ST_FIN) && out_busy, r_state == ST_FIN)
    `ASSERT_IMPL(a_out_col, i_clk, i_rst_n, 1'b1, 11'(r_out_column) < w_eff)
    `ASSERT_NEXT(a_root_end, i_clk, i_rst_n, (r_state == ST_ROOT) && (r_bit == 3'd0),
                 r_state == ST_FIN)

endmodule
